// ===== src/pse_pkg.sv =====
// shared types and constants for the postfix stack evaluator
// token and result words, command and status codes, controller interface
// no dependencies
package pse_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int DATA_W      = 64;
    localparam int ITER_W      = 7;
    localparam int MUL_LAST    = 4;
    localparam int DIV_LAST    = 95;

    typedef enum logic [2:0] {
        CMD_PUSH = 3'd0,
        CMD_ADD  = 3'd1,
        CMD_SUB  = 3'd2,
        CMD_MUL  = 3'd3,
        CMD_DIV  = 3'd4,
        CMD_END  = 3'd5
    } cmd_code_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FEW      = 3'd1,
        ST_DIVZERO  = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_LEFTOVER = 3'd4
    } status_code_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_FIN
    } state_t;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [63:0] number;
    } token_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic [2:0]         status;
    } result_t;

    // commands from controller to datapath
    typedef struct packed {
        logic         push;
        logic         rd;
        logic         addsub;
        logic         sub;
        logic         arith_start;
        logic         step;
        logic         div_sel;
        logic         finish;
        logic         emit;
        status_code_t emit_status;
        logic         clear;
    } ctl_t;

    // status from datapath to controller
    typedef struct packed {
        logic full;
        logic lt2;
        logic one;
        logic top_zero;
        logic mul_last;
        logic div_last;
        logic out_busy;
    } sts_t;

endpackage

// ===== src/pse_ram.sv =====
// generic single write, single read memory with registered read data
// no dependencies
module pse_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/pse_ctrl.sv =====
// controller state machine for the postfix stack evaluator
// depends on pse_pkg for codes, states and the command/status structs
module pse_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          token_valid,
    output logic          token_stall,
    input  logic [2:0]    cmd,
    input  pse_pkg::sts_t sts,
    output pse_pkg::ctl_t ctl
);

    pse_pkg::state_t       state_reg, state_next;
    pse_pkg::status_code_t err_reg, err_next;
    logic [2:0]            op_reg, op_next;
    logic                  accept;
    logic                  is_op;

    assign token_stall = (state_reg != pse_pkg::S_IDLE)
                       || (cmd == pse_pkg::CMD_END && sts.out_busy);
    assign accept = token_valid && !token_stall;
    assign is_op  = (cmd == pse_pkg::CMD_ADD) || (cmd == pse_pkg::CMD_SUB)
                 || (cmd == pse_pkg::CMD_MUL) || (cmd == pse_pkg::CMD_DIV);

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pse_pkg::S_IDLE;
            err_reg   <= pse_pkg::ST_OK;
            op_reg    <= pse_pkg::CMD_PUSH;
        end
        else
        begin
            state_reg <= state_next;
            err_reg   <= err_next;
            op_reg    <= op_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        err_next   = err_reg;
        op_next    = op_reg;
        case (state_reg)
            pse_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == pse_pkg::CMD_END)
                    begin
                        err_next = pse_pkg::ST_OK;
                    end
                    else if (err_reg == pse_pkg::ST_OK)
                    begin
                        if (cmd == pse_pkg::CMD_PUSH)
                        begin
                            if (sts.full)
                            begin
                                err_next = pse_pkg::ST_OVERFLOW;
                            end
                        end
                        else if (is_op)
                        begin
                            if (sts.lt2)
                            begin
                                err_next = pse_pkg::ST_FEW;
                            end
                            else if (cmd == pse_pkg::CMD_DIV && sts.top_zero)
                            begin
                                err_next = pse_pkg::ST_DIVZERO;
                            end
                            else
                            begin
                                op_next    = cmd;
                                state_next = pse_pkg::S_EXEC;
                            end
                        end
                    end
                end
            end
            pse_pkg::S_EXEC:
            begin
                if (op_reg == pse_pkg::CMD_MUL)
                begin
                    state_next = pse_pkg::S_MUL;
                end
                else if (op_reg == pse_pkg::CMD_DIV)
                begin
                    state_next = pse_pkg::S_DIV;
                end
                else
                begin
                    state_next = pse_pkg::S_IDLE;
                end
            end
            pse_pkg::S_MUL:
            begin
                if (sts.mul_last)
                begin
                    state_next = pse_pkg::S_FIN;
                end
            end
            pse_pkg::S_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = pse_pkg::S_FIN;
                end
            end
            pse_pkg::S_FIN:
            begin
                state_next = pse_pkg::S_IDLE;
            end
            default:
            begin
                state_next = pse_pkg::S_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb
    begin
        ctl             = '0;
        ctl.emit_status = pse_pkg::ST_OK;
        ctl.div_sel     = (op_reg == pse_pkg::CMD_DIV);
        ctl.sub         = (op_reg == pse_pkg::CMD_SUB);
        case (state_reg)
            pse_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == pse_pkg::CMD_END)
                    begin
                        ctl.emit  = 1'b1;
                        ctl.clear = 1'b1;
                        if (err_reg != pse_pkg::ST_OK)
                        begin
                            ctl.emit_status = err_reg;
                        end
                        else if (!sts.one)
                        begin
                            ctl.emit_status = pse_pkg::ST_LEFTOVER;
                        end
                    end
                    else if (err_reg == pse_pkg::ST_OK)
                    begin
                        if (cmd == pse_pkg::CMD_PUSH)
                        begin
                            ctl.push = !sts.full;
                        end
                        else if (is_op && !sts.lt2
                                 && !(cmd == pse_pkg::CMD_DIV && sts.top_zero))
                        begin
                            ctl.rd = 1'b1;
                        end
                    end
                end
            end
            pse_pkg::S_EXEC:
            begin
                if (op_reg == pse_pkg::CMD_MUL || op_reg == pse_pkg::CMD_DIV)
                begin
                    ctl.arith_start = 1'b1;
                end
                else
                begin
                    ctl.addsub = 1'b1;
                end
            end
            pse_pkg::S_MUL, pse_pkg::S_DIV:
            begin
                ctl.step = 1'b1;
            end
            pse_pkg::S_FIN:
            begin
                ctl.finish = 1'b1;
            end
            default:
            begin
                ctl.emit_status = pse_pkg::ST_OK;
            end
        endcase
    end

endmodule

// ===== src/pse_dpath.sv =====
// datapath: operand stack with top in a register, q32.32 arithmetic, result register
// depends on pse_pkg and pse_ram
module pse_dpath #(
    parameter int DEPTH = pse_pkg::STACK_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pse_pkg::token_t  token,
    input  pse_pkg::ctl_t    ctl,
    output pse_pkg::sts_t    sts,
    output logic             result_valid,
    input  logic             result_stall,
    output pse_pkg::result_t result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int ITER_WL = pse_pkg::ITER_W;
    localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    logic [CW-1:0]      count_reg, count_next;
    logic [63:0]        top_reg, top_next;
    logic [63:0]        ma_reg, mb_reg;
    logic               neg_reg;
    logic [127:0]       acc_reg;
    logic [63:0]        pp_reg;
    logic [63:0]        rem_reg, quo_reg;
    logic               big_reg;
    logic [ITER_WL-1:0] iter_reg;
    logic               out_valid_reg, out_valid_next;
    pse_pkg::result_t   out_reg;

    logic [63:0]  lhs;
    logic [CW-1:0] wr_cnt, rd_cnt;
    logic [63:0]  sum, diff, addsub_res;
    logic         sum_ovf, diff_ovf;
    logic [31:0]  a_part, b_part;
    logic [1:0]   acc_idx;
    logic [127:0] pp_shifted;
    logic [63:0]  rem_sh;
    logic [64:0]  trial;
    logic [63:0]  fin_mag;
    logic         fin_big;
    logic [63:0]  fin_res;

    function automatic logic [63:0] magn(input logic [63:0] v);
        magn = v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic [63:0] signed_sat(input logic [63:0] mag, input logic neg,
                                               input logic big);
        if (neg)
        begin
            signed_sat = (big || mag > SAT_MIN) ? SAT_MIN : (64'd0 - mag);
        end
        else
        begin
            signed_sat = (big || mag[63]) ? SAT_MAX : mag;
        end
    endfunction

    // stack memory below the top entry
    assign wr_cnt = count_reg - CW'(1);
    assign rd_cnt = count_reg - CW'(2);

    pse_ram #(
        .WIDTH (64),
        .DEPTH (DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ctl.push && (count_reg != '0)),
        .waddr (wr_cnt[AW-1:0]),
        .wdata (top_reg),
        .re    (ctl.rd),
        .raddr (rd_cnt[AW-1:0]),
        .rdata (lhs)
    );

    // status toward the controller
    assign sts.full     = (count_reg == CW'(DEPTH));
    assign sts.lt2      = (count_reg < CW'(2));
    assign sts.one      = (count_reg == CW'(1));
    assign sts.top_zero = (top_reg == 64'd0);
    assign sts.mul_last = (iter_reg == ITER_WL'(pse_pkg::MUL_LAST));
    assign sts.div_last = (iter_reg == ITER_WL'(pse_pkg::DIV_LAST));
    assign sts.out_busy = out_valid_reg && result_stall;

    // saturating add and subtract, top entry is the right operand
    always_comb
    begin
        sum        = lhs + top_reg;
        diff       = lhs - top_reg;
        sum_ovf    = (lhs[63] == top_reg[63]) && (sum[63] != lhs[63]);
        diff_ovf   = (lhs[63] != top_reg[63]) && (diff[63] != lhs[63]);
        addsub_res = ctl.sub ? (diff_ovf ? (lhs[63] ? SAT_MIN : SAT_MAX) : diff)
                             : (sum_ovf  ? (lhs[63] ? SAT_MIN : SAT_MAX) : sum);
    end

    // multiply partial product select and accumulate shift
    always_comb
    begin
        a_part  = iter_reg[0] ? ma_reg[63:32] : ma_reg[31:0];
        b_part  = iter_reg[1] ? mb_reg[63:32] : mb_reg[31:0];
        acc_idx = iter_reg[1:0] - 2'd1;
        case (acc_idx)
            2'd0:    pp_shifted = {64'd0, pp_reg};
            2'd3:    pp_shifted = {pp_reg, 64'd0};
            default: pp_shifted = {32'd0, pp_reg, 32'd0};
        endcase
    end

    // one restoring divide step
    always_comb
    begin
        rem_sh = {rem_reg[62:0], ma_reg[63]};
        trial  = {1'b0, rem_sh} - {1'b0, mb_reg};
    end

    // final sign and saturation of multiply or divide
    always_comb
    begin
        fin_mag = ctl.div_sel ? quo_reg : acc_reg[95:32];
        fin_big = ctl.div_sel ? big_reg : (acc_reg[127:96] != 32'd0);
        fin_res = signed_sat(fin_mag, neg_reg, fin_big);
    end

    // stack count and top entry
    always_comb
    begin
        count_next = count_reg;
        top_next   = top_reg;
        if (ctl.clear)
        begin
            count_next = '0;
        end
        else if (ctl.push)
        begin
            count_next = count_reg + CW'(1);
            top_next   = token.number;
        end
        else if (ctl.addsub)
        begin
            count_next = count_reg - CW'(1);
            top_next   = addsub_res;
        end
        else if (ctl.finish)
        begin
            count_next = count_reg - CW'(1);
            top_next   = fin_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
    end

    // iterative multiply and divide unit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
        end
        else if (ctl.arith_start)
        begin
            iter_reg <= '0;
        end
        else if (ctl.step)
        begin
            iter_reg <= iter_reg + ITER_WL'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.arith_start)
        begin
            ma_reg  <= magn(lhs);
            mb_reg  <= magn(top_reg);
            neg_reg <= lhs[63] ^ top_reg[63];
            acc_reg <= '0;
            rem_reg <= '0;
            quo_reg <= '0;
            big_reg <= 1'b0;
        end
        else if (ctl.step)
        begin
            if (ctl.div_sel)
            begin
                ma_reg <= {ma_reg[62:0], 1'b0};
                if (quo_reg[63])
                begin
                    big_reg <= 1'b1;
                end
                if (!trial[64])
                begin
                    rem_reg <= trial[63:0];
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
            end
            else
            begin
                if (iter_reg < ITER_WL'(pse_pkg::MUL_LAST))
                begin
                    pp_reg <= a_part * b_part;
                end
                if (iter_reg != '0)
                begin
                    acc_reg <= acc_reg + pp_shifted;
                end
            end
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            out_reg.value  <= (ctl.emit_status == pse_pkg::ST_OK) ? top_reg : 64'd0;
            out_reg.status <= ctl.emit_status;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== src/postfix_stack_evaluator.sv =====
// top level of the postfix stack evaluator
// depends on pse_pkg, pse_ctrl, pse_dpath (which holds pse_ram)
//
//   channel   direction  handshake                    word
//   token     in         token_valid / token_stall    pse_pkg::token_t  (cmd, number)
//   result    out        result_valid / result_stall  pse_pkg::result_t (value, status)
//
// push, end and ignored tokens are handled in idle; add and subtract also pass through exec
// multiply goes through exec, mul and fin: four 32x32 partial products through one multiplier
// divide goes through exec, div and fin: the restoring divider retires one quotient bit a cycle
// reset clears the stack count, pending error and result valid; no clearing pass
// an end token waits while a previous result is held by result_stall
module postfix_stack_evaluator #(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             token_valid,
    output logic             token_stall,
    input  pse_pkg::token_t  token,
    output logic             result_valid,
    input  logic             result_stall,
    output pse_pkg::result_t result
);

    pse_pkg::ctl_t ctl;
    pse_pkg::sts_t sts;

    // sequencing
    pse_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .cmd         (token.cmd),
        .sts         (sts),
        .ctl         (ctl)
    );

    // stack and arithmetic
    pse_dpath #(
        .DEPTH (STACK_DEPTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .token        (token),
        .ctl          (ctl),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
